@@ hdl/smmd_pkg.sv @@
// ----------------------------------------------------------------------------
// smmd_pkg
// Types, constants and helpers shared by the rounded multiply-divide block.
// ----------------------------------------------------------------------------
package smmd_pkg;

  localparam int unsigned NumCells = 64;       // one quotient bit per divider cell
  localparam int unsigned BitBudget = 31;
  localparam logic [31:0] QuotMin = 32'h8000_0000;
  localparam logic [31:0] QuotMax = 32'h7FFF_FFFF;

  // One operand set as it arrives on the input channel.
  typedef struct packed {
    logic signed [31:0] scale_factor;
    logic signed [31:0] mult_a;
    logic signed [31:0] mult_b;
    logic signed [31:0] div_a;
    logic signed [31:0] div_b;
  } smmd_op_t;

  // Work item that travels down the divider chain.
  typedef struct packed {
    logic [63:0] rem;    // partial remainder
    logic [63:0] qd;     // dividend bits still to use, quotient bits shifted in
    logic [62:0] den;    // divisor, never negative
    logic        neg;    // result sign
    logic        zero;   // divisor is zero, result saturates
  } smmd_div_t;

  // Number of significant bits of an unsigned value.
  function automatic logic [6:0] bitlen64(input logic [63:0] m);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) begin
        n = 7'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

@@ hdl/smmd_if.sv @@
// ----------------------------------------------------------------------------
// smmd_in_if / smmd_out_if
// Valid/ready channels carrying operand sets and results.
// ----------------------------------------------------------------------------
interface smmd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] scale_factor;
  logic signed [31:0] mult_a;
  logic signed [31:0] mult_b;
  logic signed [31:0] div_a;
  logic signed [31:0] div_b;

  modport source (output valid, scale_factor, mult_a, mult_b, div_a, div_b, input ready);
  modport sink   (input valid, scale_factor, mult_a, mult_b, div_a, div_b, output ready);
endinterface

interface smmd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quotient;

  modport source (output valid, quotient, input ready);
  modport sink   (input valid, quotient, output ready);
endinterface

@@ hdl/smmd_front.sv @@
// ----------------------------------------------------------------------------
// smmd_front
// Products, normalizing shifts and rounding offset ahead of the divider chain.
// ----------------------------------------------------------------------------
module smmd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  smmd_pkg::smmd_op_t  data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output smmd_pkg::smmd_div_t data_o
);
  import smmd_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic r1, r2, r3, r4, r5;

  // Stage 1: the two 64-bit products.
  logic signed [31:0] fac1_q;
  logic signed [63:0] num1_q, den1_q;
  // Stage 2: sign fix and shift amounts.
  logic signed [31:0] fac2_q;
  logic signed [63:0] num2_q, den2_q;
  logic [6:0]         k2_q, kf2_q, kn2_q;
  // Stage 3: shifted operands.
  logic signed [31:0] fac3_q;
  logic signed [63:0] num3_q;
  logic [63:0]        den3_q;
  // Stage 4: partial products.
  logic [63:0]        pplo4_q;
  logic [31:0]        pphi4_q;
  logic [63:0]        den4_q;
  // Stage 5: dividend ready for the chain.
  smmd_div_t          d5_q;

  assign r5 = !v5_q || ready_i;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign ready_o = r1;
  assign valid_o = v5_q;
  assign data_o  = d5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
      if (r5) v5_q <= v4_q;
    end
  end

  // Stage 2 logic.
  logic signed [63:0] fac_ext;
  logic [63:0]        num_mag, fac_mag;
  logic [6:0]         total, k_c, kf_c;
  logic [15:0]        kmul;
  always_comb begin
    fac_ext = 64'(fac1_q);
    num_mag = num1_q[63] ? 64'(-num1_q) : num1_q;
    fac_mag = fac_ext[63] ? 64'(-fac_ext) : fac_ext;
    total   = bitlen64(num_mag) + bitlen64(fac_mag);
    k_c     = (total > 7'(BitBudget)) ? total - 7'(BitBudget) : 7'd0;
    // k / 3 by reciprocal, exact over the range of k.
    kmul    = {9'd0, k_c} * 16'd171;
    kf_c    = kmul[15:9];
  end

  // Stage 3 logic.
  logic [63:0] den_sh;
  always_comb begin
    den_sh = (k2_q > 7'd63) ? 64'd0 : (64'(den2_q) >> k2_q[5:0]);
  end

  // Stage 4 logic: 64 x 32 product split into two partial products.
  logic signed [64:0] pplo_c;
  logic signed [63:0] pphi_c;
  always_comb begin
    pplo_c = $signed({1'b0, num3_q[31:0]}) * fac3_q;
    pphi_c = $signed(num3_q[63:32]) * fac3_q;
  end

  // Stage 5 logic.
  logic [63:0] prod_c, sum_c;
  always_comb begin
    prod_c = pplo4_q + {pphi4_q, 32'd0};
    sum_c  = prod_c + (den4_q >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      fac1_q <= data_i.scale_factor;
      num1_q <= data_i.mult_a * data_i.mult_b;
      den1_q <= data_i.div_a * data_i.div_b;
    end
    if (r2 && v1_q) begin
      fac2_q <= fac1_q;
      num2_q <= den1_q[63] ? -num1_q : num1_q;
      den2_q <= den1_q[63] ? -den1_q : den1_q;
      k2_q   <= k_c;
      kf2_q  <= kf_c;
      kn2_q  <= k_c - kf_c;
    end
    if (r3 && v2_q) begin
      fac3_q <= fac2_q >>> kf2_q[4:0];
      num3_q <= num2_q >>> kn2_q[5:0];
      den3_q <= den_sh;
    end
    if (r4 && v3_q) begin
      pplo4_q <= pplo_c[63:0];
      pphi4_q <= pphi_c[31:0];
      den4_q  <= den3_q;
    end
    if (r5 && v4_q) begin
      d5_q.rem  <= '0;
      d5_q.den  <= den4_q[62:0];
      d5_q.zero <= (den4_q == 64'd0);
      if (den4_q == 64'd0) begin
        d5_q.neg <= prod_c[63];
        d5_q.qd  <= sum_c;
      end else begin
        d5_q.neg <= sum_c[63];
        d5_q.qd  <= sum_c[63] ? -sum_c : sum_c;
      end
    end
  end

endmodule

@@ hdl/smmd_div_cell.sv @@
// ----------------------------------------------------------------------------
// smmd_div_cell
// One restoring-division step: develops one quotient bit and hands on.
// ----------------------------------------------------------------------------
module smmd_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  smmd_pkg::smmd_div_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output smmd_pkg::smmd_div_t data_o
);
  import smmd_pkg::*;

  logic      valid_q;
  smmd_div_t data_q, data_d;
  logic [63:0] shifted;
  logic        take;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    shifted = {data_i.rem[62:0], data_i.qd[63]};
    take    = (shifted >= {1'b0, data_i.den});
    data_d  = data_i;
    data_d.rem = take ? shifted - {1'b0, data_i.den} : shifted;
    data_d.qd  = {data_i.qd[62:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

@@ hdl/scaled_mul_mul_div_div_top.sv @@
// ----------------------------------------------------------------------------
// scaled_mul_mul_div_div_top
// Rounded scale_factor * mult_a * mult_b / (div_a * div_b), signed 32-bit.
// ----------------------------------------------------------------------------
// Usage: operand sets enter on in_i, a valid/ready channel; a transfer takes
// place at a rising edge with valid and ready both high. Each transfer gives
// exactly one transfer of quotient on out_o, in arrival order.
// The pipeline has five front stages (products, shift amounts, shifts, partial
// products, rounding offset), a chain of 64 division cells that each develop
// one quotient bit, and one output register applying the sign and the
// saturation for a zero divisor.
// Throughput is one operand set per cycle while out_o.ready is high; every stage
// holds one item and the 64-cell divider chain sets the latency, not the rate.
// When the receiver stalls, items keep moving into empty stages, so the input
// stays ready until every stage holds an item; then in_i.ready falls and the
// pipeline holds its contents until out_o.ready returns.
// Reset (rst_ni low, asynchronous) empties every stage; no item survives it.
// A zero divisor after normalization yields 32'h80000000 for a negative
// scaled numerator and 32'h7FFFFFFF otherwise.
// ----------------------------------------------------------------------------
module scaled_mul_mul_div_div_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  smmd_in_if.sink    in_i,
  smmd_out_if.source out_o
);
  import smmd_pkg::*;

  smmd_op_t  op;
  logic      cv [NumCells+1];
  logic      cr [NumCells+1];
  smmd_div_t cd [NumCells+1];

  assign op.scale_factor = in_i.scale_factor;
  assign op.mult_a       = in_i.mult_a;
  assign op.mult_b       = in_i.mult_b;
  assign op.div_a        = in_i.div_a;
  assign op.div_b        = in_i.div_b;

  smmd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  (op),
    .valid_o (cv[0]),
    .ready_i (cr[0]),
    .data_o  (cd[0])
  );

  // The division chain: each cell passes its item to the next one.
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    smmd_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[g]),
      .ready_o (cr[g]),
      .data_i  (cd[g]),
      .valid_o (cv[g+1]),
      .ready_i (cr[g+1]),
      .data_o  (cd[g+1])
    );
  end

  // Output register: sign, saturation and the low 32 bits.
  logic        out_valid_q;
  logic [31:0] quot_q, quot_d;
  logic        zero_q;

  assign cr[NumCells] = !out_valid_q || out_o.ready;
  assign out_o.valid    = out_valid_q;
  assign out_o.quotient = quot_q;

  always_comb begin
    if (cd[NumCells].zero) begin
      quot_d = cd[NumCells].neg ? QuotMin : QuotMax;
    end else if (cd[NumCells].neg) begin
      quot_d = 32'(-cd[NumCells].qd);
    end else begin
      quot_d = cd[NumCells].qd[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cr[NumCells]) begin
      out_valid_q <= cv[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cr[NumCells] && cv[NumCells]) begin
      quot_q <= quot_d;
      zero_q <= cd[NumCells].zero;
    end
  end

  // An empty output stage means no stage anywhere can block the input.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready) else $error("input blocked with empty output");

  // A receiver that is always ready never throttles the input.
  a_flow_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready) else $error("input blocked while output drains");

  // A zero divisor must always come out saturated.
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && zero_q) |-> (quot_q == QuotMin || quot_q == QuotMax))
    else $error("zero divisor result not saturated");

endmodule
